@@ hw/rtl/assert_macros.svh @@
// Assertion helpers shared by the RTL modules.
// Both sample on clk and stay quiet while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// prop must hold at every clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// expr must never be true outside reset
`define ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

@@ hw/rtl/hdbd_pkg.sv @@
package hdbd_pkg;

  localparam int MAX_WIDTH   = 1024;
  localparam int MAX_HEIGHT  = 4096;
  localparam int COL_W       = $clog2(MAX_WIDTH);
  localparam int ADDR_W      = COL_W + 1;
  localparam int STORE_DEPTH = 2 * MAX_WIDTH;
  localparam int ROW_W       = $clog2(MAX_HEIGHT);
  localparam int FW_W        = 11;
  localparam int FH_W        = 13;
  localparam int BUF_W       = 15;
  localparam int CNT_W       = 4;
  localparam int MAX_RESULTS = 8;
  localparam int RES_W       = 4;
  localparam int PADDR_W     = 3;

  localparam logic [FW_W-1:0] WIDTH_RESET  = 11'd352;
  localparam logic [FH_W-1:0] HEIGHT_RESET = 13'd288;

  // register index codes (paddr[2])
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  typedef struct packed {
    logic load;       // take in a new byte
    logic step;       // decode one pixel into the hold register
    logic push;       // move hold register to the output register
    logic push_last;  // pushed pixel is the last one of its byte
  } hdbd_cmd_t;

  typedef struct packed {
    logic can_decode;
    logic frame_done;
  } hdbd_status_t;

  typedef struct packed {
    logic [CNT_W-1:0]  len;
    logic signed [8:0] delta;
    logic              is_abs;
  } hdbd_code_t;

  // prefix code lookup on a left-aligned 8-bit window
  function automatic hdbd_code_t classify(input logic [7:0] w);
    hdbd_code_t c;
    c.len    = 4'd8;
    c.delta  = 9'sd0;
    c.is_abs = 1'b0;
    case (w) inside
      8'b0???????: c.len = 4'd1;
      8'b100?????: begin c.len = 4'd3; c.delta = 9'sd4;   end
      8'b101?????: begin c.len = 4'd3; c.delta = -9'sd4;  end
      8'b1101????: begin c.len = 4'd4; c.delta = 9'sd11;  end
      8'b1111????: begin c.len = 4'd4; c.delta = -9'sd11; end
      8'b11001???: begin c.len = 4'd5; c.delta = 9'sd20;  end
      8'b110000??: begin c.len = 4'd6; c.delta = -9'sd20; end
      8'b110001??: c.len = 4'd8;
      8'b1110????: begin
        c.len    = 4'd8;
        c.is_abs = 1'b1;
        c.delta  = {1'b0, w[3:0], 4'b0000};
      end
      default: c.len = 4'd8;
    endcase
    return c;
  endfunction

endpackage

@@ hw/rtl/hdbd_ram.sv @@
module hdbd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/hdbd_ctrl.sv @@
module hdbd_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output hdbd_pkg::hdbd_cmd_t    cmd,
  input  hdbd_pkg::hdbd_status_t st
);
  import hdbd_pkg::*;
  `include "assert_macros.svh"

  typedef enum logic {S_IDLE, S_RUN} state_t;

  state_t           state, state_next;
  logic [RES_W-1:0] res_count, res_count_next;
  logic             hold_valid, hold_valid_next;
  logic             out_valid, out_valid_next;
  logic             go, out_free;

  assign s_tready = (state == S_IDLE);
  assign m_tvalid = out_valid;

  always_comb begin
    go              = st.can_decode && (res_count < RES_W'(MAX_RESULTS));
    out_free        = !out_valid || m_tready;
    cmd             = '0;
    state_next      = state;
    res_count_next  = res_count;
    hold_valid_next = hold_valid;
    out_valid_next  = out_valid && !m_tready;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.load       = 1'b1;
          res_count_next = '0;
          state_next     = S_RUN;
        end
      end
      S_RUN: begin
        cmd.push      = hold_valid && out_free;
        cmd.push_last = !go;
        cmd.step      = go && (!hold_valid || out_free);
        if (cmd.push) begin
          out_valid_next  = 1'b1;
          hold_valid_next = 1'b0;
        end
        if (cmd.step) begin
          hold_valid_next = 1'b1;
          res_count_next  = res_count + RES_W'(1);
        end
        if (!go && (!hold_valid || out_free)) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      res_count  <= '0;
      hold_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      res_count  <= res_count_next;
      hold_valid <= hold_valid_next;
      out_valid  <= out_valid_next;
    end
  end

  `ASSERT_NEVER(a_idle_hold_empty, (state == S_IDLE) && hold_valid,
      "pixel left in hold register at end of word")
  `ASSERT_CLK(a_step_budget, cmd.step |-> (res_count < RES_W'(MAX_RESULTS)),
      "more than eight pixels from one word")
  `ASSERT_CLK(a_last_push_ends, (cmd.push && cmd.push_last) |=> (state == S_IDLE),
      "decoder kept running after last pixel of word")

endmodule

@@ hw/rtl/hdbd_datapath.sv @@
module hdbd_datapath (
  input  logic                       clk,
  input  logic                       rst,
  input  hdbd_pkg::hdbd_cmd_t         cmd,
  output hdbd_pkg::hdbd_status_t      st,
  input  logic [7:0]                 comp_byte,
  input  logic                       frame_start,
  input  logic [hdbd_pkg::FW_W-1:0]  frame_width,
  input  logic [hdbd_pkg::FH_W-1:0]  frame_height,
  output logic [7:0]                 pixel,
  output logic                       last_of_byte,
  output logic                       last_of_frame
);
  import hdbd_pkg::*;
  `include "assert_macros.svh"

  // bitstream and position state
  logic [BUF_W-1:0] bit_buffer, bit_buffer_next;
  logic [CNT_W-1:0] bit_count, bit_count_next;
  logic [ROW_W-1:0] row_index, row_index_next;
  logic [COL_W-1:0] col_index, col_index_next;
  logic             frame_done, frame_done_next;

  // last two pixels, newest in left_hist0
  logic [7:0] left_hist0, left_hist1;
  logic [7:0] hold_pixel;
  logic       hold_eof;

  logic [BUF_W+7:0]   shifted;
  logic [7:0]         win;
  hdbd_code_t         code;
  logic               is_raw;
  logic [CNT_W-1:0]   len, cnt_after;
  logic [BUF_W-1:0]   keep_mask;
  logic [7:0]         above, pred;
  logic [8:0]         avg_sum;
  logic signed [9:0]  sum;
  logic [7:0]         val;
  logic [FW_W-1:0]    eff_w, col_inc;
  logic [FH_W-1:0]    eff_h, row_inc;
  logic               row_end, frame_end;
  logic [BUF_W-1:0]   base_buf;
  logic [CNT_W-1:0]   base_cnt;
  logic               base_done;

  hdbd_ram #(.WIDTH(8), .DEPTH(STORE_DEPTH)) u_store (
    .clk   (clk),
    .we    (cmd.step),
    .waddr ({row_index[0], col_index}),
    .wdata (val),
    .raddr ({row_index_next[0], col_index_next}),
    .rdata (above)
  );

  always_comb begin
    eff_w = frame_width;
    if (frame_width < FW_W'(2)) eff_w = FW_W'(2);
    else if (frame_width > FW_W'(MAX_WIDTH)) eff_w = FW_W'(MAX_WIDTH);
    eff_h = frame_height;
    if (frame_height < FH_W'(1)) eff_h = FH_W'(1);
    else if (frame_height > FH_W'(MAX_HEIGHT)) eff_h = FH_W'(MAX_HEIGHT);

    // next eight bits of the stream, zero padded past the end
    shifted = {bit_buffer, 8'h00} >> bit_count;
    win     = shifted[7:0];
    code    = classify(win);
    is_raw  = (row_index[ROW_W-1:1] == '0) && (col_index[COL_W-1:1] == '0);
    len     = is_raw ? CNT_W'(8) : code.len;

    st.frame_done = frame_done;
    st.can_decode = !frame_done && (len <= bit_count);

    avg_sum = {1'b0, left_hist1} + {1'b0, above};
    if (col_index[COL_W-1:1] == '0) pred = above;
    else if (row_index[ROW_W-1:1] == '0) pred = left_hist1;
    else pred = avg_sum[8:1];

    sum = {code.delta[8], code.delta} + (code.is_abs ? 10'sd0 : signed'({2'b00, pred}));
    if (sum[9]) val = 8'd0;
    else if (sum[8]) val = 8'd255;
    else val = sum[7:0];
    if (is_raw) val = win;

    cnt_after = bit_count - len;
    keep_mask = ~({BUF_W{1'b1}} << cnt_after);
    col_inc   = {1'b0, col_index} + FW_W'(1);
    row_inc   = {1'b0, row_index} + FH_W'(1);
    row_end   = col_inc >= eff_w;
    frame_end = row_end && (row_inc >= eff_h);

    bit_buffer_next = bit_buffer;
    bit_count_next  = bit_count;
    row_index_next  = row_index;
    col_index_next  = col_index;
    frame_done_next = frame_done;

    base_buf  = frame_start ? '0 : bit_buffer;
    base_cnt  = frame_start ? '0 : bit_count;
    base_done = frame_start ? 1'b0 : frame_done;

    if (cmd.load) begin
      if (frame_start) begin
        row_index_next = '0;
        col_index_next = '0;
      end
      frame_done_next = base_done;
      bit_buffer_next = base_buf;
      bit_count_next  = base_cnt;
      if (!base_done) begin
        bit_buffer_next = {base_buf[BUF_W-9:0], comp_byte};
        bit_count_next  = base_cnt + CNT_W'(8);
      end
    end else if (cmd.step) begin
      bit_count_next  = cnt_after;
      bit_buffer_next = bit_buffer & keep_mask;
      col_index_next  = row_end ? '0 : col_inc[COL_W-1:0];
      if (row_end) begin
        row_index_next = frame_end ? '0 : row_inc[ROW_W-1:0];
      end
      if (frame_end) begin
        frame_done_next = 1'b1;
        bit_buffer_next = '0;
        bit_count_next  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_buffer <= '0;
      bit_count  <= '0;
      row_index  <= '0;
      col_index  <= '0;
      frame_done <= 1'b1;
    end else begin
      bit_buffer <= bit_buffer_next;
      bit_count  <= bit_count_next;
      row_index  <= row_index_next;
      col_index  <= col_index_next;
      frame_done <= frame_done_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      left_hist1 <= left_hist0;
      left_hist0 <= val;
      hold_pixel <= val;
      hold_eof   <= frame_end;
    end
    if (cmd.push) begin
      pixel         <= hold_pixel;
      last_of_frame <= hold_eof;
      last_of_byte  <= cmd.push_last;
    end
  end

  `ASSERT_CLK(a_load_leftover, (cmd.load && !frame_start) |-> (bit_count <= CNT_W'(7)),
      "more than seven bits left over from previous word")
  `ASSERT_CLK(a_frame_end_clears, (cmd.step && frame_end) |=>
      (frame_done && (bit_count == '0) && (row_index == '0) && (col_index == '0)),
      "state not cleared at end of frame")
  `ASSERT_CLK(a_start_opens_frame, (cmd.load && frame_start) |=>
      (!frame_done && (bit_count == CNT_W'(8))),
      "frame start did not open a new frame")

endmodule

@@ hw/rtl/huffman_dpcm_bayer_decoder_core.sv @@
// Flow: a word is loaded into the bit buffer; each pixel is decoded into the hold register, then
//   pushed to the output register on m_tdata. Throughput: one pixel per cycle while m_tready
//   does not stall the output; a word yields 0..8 pixels; the bit buffer decode/update loop sets this rate.
// s_tready is high only between words; a finished pixel may wait in the output register.
// Reset (rst, synchronous): counters and bit buffer cleared, decoder waits for frame start,
//   frame_width 352 and frame_height 288. Line store holds no reset value.
module huffman_dpcm_bayer_decoder_core (
  input  logic                          clk,
  input  logic                          rst,
  // input words
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [7:0]                    s_tdata,   // [7:0] comp_byte
  input  logic                          s_tuser,   // [0] frame_start
  // output words
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [7:0]                    m_tdata,   // [7:0] pixel
  output logic                          m_tlast,   // last_of_frame
  output logic                          m_tuser,   // [0] last_of_byte
  // register port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [hdbd_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import hdbd_pkg::*;

  // Register map (byte addresses):
  //   0x0 frame_width  [10:0]  pixels per row, used clamped to 2..1024
  //   0x4 frame_height [12:0]  rows per frame, used clamped to 1..4096
  // The user must write these only while the decoder is idle; the block does not enforce it.
  logic [FW_W-1:0] frame_width;
  logic [FH_W-1:0] frame_height;
  logic            reg_idx;
  logic            reg_wr;

  hdbd_cmd_t    cmd;
  hdbd_status_t st;

  assign pready  = 1'b1;
  assign reg_idx = paddr[2];
  assign reg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= WIDTH_RESET;
      frame_height <= HEIGHT_RESET;
    end else if (reg_wr) begin
      case (reg_idx)
        REG_WIDTH:  frame_width  <= pwdata[FW_W-1:0];
        REG_HEIGHT: frame_height <= pwdata[FH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_WIDTH:  prdata = {{(32-FW_W){1'b0}}, frame_width};
      REG_HEIGHT: prdata = {{(32-FH_W){1'b0}}, frame_height};
      default:    prdata = '0;
    endcase
  end

  // Controller: takes words, paces pixel decode, owns the output handshake.
  // A decoded pixel sits in a hold register until the next decode attempt
  // shows whether it was the last one of its word.
  hdbd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd),
    .st       (st)
  );

  // Datapath: bit buffer, prefix decode, prediction, clamp, two-line store.
  hdbd_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .st            (st),
    .comp_byte     (s_tdata),
    .frame_start   (s_tuser),
    .frame_width   (frame_width),
    .frame_height  (frame_height),
    .pixel         (m_tdata),
    .last_of_byte  (m_tuser),
    .last_of_frame (m_tlast)
  );

endmodule
